>>> src/key_table_sort_and_search_defines.svh
// Assertion macros used by the checker module.
`ifndef KEY_TABLE_SORT_AND_SEARCH_DEFINES_SVH
`define KEY_TABLE_SORT_AND_SEARCH_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define KTSS_ASSERT_SAME(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ktss check failed");

// Check that a condition implies another in the next cycle.
`define KTSS_ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ktss check failed");

`endif

>>> src/ktss_pkg.sv
package ktss_pkg;

    localparam int KEY_W           = 64;
    localparam int CMD_W           = 2;
    localparam int IDX_W           = 10;
    localparam int TABLE_DEPTH_DEF = 1024;

    typedef logic [IDX_W-1:0] t_index;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SORT   = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    // Datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_CLEAR,
        OP_LOAD,
        OP_SRCH_INIT,
        OP_SRCH_RD,
        OP_SRCH_CMP,
        OP_SORT_INIT,
        OP_POP,
        OP_POP_TAKE,
        OP_PIVOT,
        OP_RDJ,
        OP_CMPJ,
        OP_SWPA,
        OP_SWPB,
        OP_FIN_WA,
        OP_FIN_WB,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_SRCH_INIT,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_TAKE,
        ST_PIVOT,
        ST_RDJ,
        ST_CMPJ,
        ST_SWPA,
        ST_SWPB,
        ST_FIN_WA,
        ST_FIN_WB,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic count_lt2;
        logic srch_open;
        logic hit;
        logic sp_zero;
        logic j_at_hi;
        logic swap_need;
    } t_dp_stat;

endpackage

>>> src/ktss_if.sv
interface ktss_in_if;
    logic                         valid;
    logic                         ready;
    logic [ktss_pkg::CMD_W-1:0]   cmd;
    logic [ktss_pkg::KEY_W-1:0]   key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface ktss_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic                         found;
    logic [ktss_pkg::IDX_W-1:0]   index;

    modport source (output valid, output status, output found, output index, input ready);
    modport sink   (input valid, input status, input found, input index, output ready);
endinterface

>>> src/ktss_datapath.sv
module ktss_datapath #(
    parameter int TABLE_DEPTH = ktss_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ktss_pkg::t_dp_op           i_op,
    input  logic [ktss_pkg::KEY_W-1:0] i_key,
    output ktss_pkg::t_dp_stat         o_stat,
    output logic                       o_status,
    output logic                       o_found,
    output ktss_pkg::t_index           o_index
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Memories
    logic [ktss_pkg::KEY_W-1:0] r_key_mem [TABLE_DEPTH];
    logic [2*AW-1:0]            r_stk_mem [TABLE_DEPTH];

    logic [ktss_pkg::KEY_W-1:0] r_rdata;
    logic [2*AW-1:0]            r_sdata;

    // Control registers
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sp, n_sp;

    // Payload registers
    logic [ktss_pkg::KEY_W-1:0] r_key, n_key;
    logic [ktss_pkg::KEY_W-1:0] r_pivot, n_pivot;
    logic [ktss_pkg::KEY_W-1:0] r_vj, n_vj;
    logic [ktss_pkg::KEY_W-1:0] r_vi, n_vi;
    logic [CW-1:0]              r_lo, n_lo;
    logic [CW-1:0]              r_hix, n_hix;
    logic [AW-1:0]              r_slo, n_slo;
    logic [AW-1:0]              r_shi, n_shi;
    logic [AW-1:0]              r_ip, n_ip;
    logic [AW-1:0]              r_j, n_j;
    logic                       r_status, n_status;
    logic                       r_found, n_found;
    ktss_pkg::t_index           r_index, n_index;
    logic                       r_ostatus, n_ostatus;
    logic                       r_ofound, n_ofound;
    ktss_pkg::t_index           r_oindex, n_oindex;

    logic                       rd_en, wr_en, stk_re, stk_we;
    logic [AW-1:0]              rd_addr, wr_addr, stk_ra, stk_wa;
    logic [ktss_pkg::KEY_W-1:0] wr_data;
    logic [2*AW-1:0]            stk_wd;
    logic [CW-1:0]              mid_full;
    logic [AW-1:0]              mid;

    // Midpoint of the open search range
    assign mid_full = r_lo + ((r_hix - r_lo - CW'(1)) >> 1);
    assign mid      = mid_full[AW-1:0];

    // Status toward the controller
    assign o_stat.count_lt2 = (r_count < CW'(2));
    assign o_stat.srch_open = (r_lo < r_hix);
    assign o_stat.hit       = (r_rdata == r_key);
    assign o_stat.sp_zero   = (r_sp == '0);
    assign o_stat.j_at_hi   = (r_j == r_shi);
    assign o_stat.swap_need = (r_rdata <= r_pivot) && (r_ip != r_j);

    assign o_status = r_ostatus;
    assign o_found  = r_ofound;
    assign o_index  = r_oindex;

    // Decode the operation
    always_comb begin
        n_count   = r_count;
        n_sp      = r_sp;
        n_key     = r_key;
        n_pivot   = r_pivot;
        n_vj      = r_vj;
        n_vi      = r_vi;
        n_lo      = r_lo;
        n_hix     = r_hix;
        n_slo     = r_slo;
        n_shi     = r_shi;
        n_ip      = r_ip;
        n_j       = r_j;
        n_status  = r_status;
        n_found   = r_found;
        n_index   = r_index;
        n_ostatus = r_ostatus;
        n_ofound  = r_ofound;
        n_oindex  = r_oindex;
        rd_en     = 1'b0;
        rd_addr   = r_j;
        wr_en     = 1'b0;
        wr_addr   = r_ip;
        wr_data   = r_vj;
        stk_re    = 1'b0;
        stk_ra    = r_sp[AW-1:0] - AW'(1);
        stk_we    = 1'b0;
        stk_wa    = r_sp[AW-1:0];
        stk_wd    = {r_slo, r_shi};
        unique case (i_op)
            ktss_pkg::OP_NOP: begin
            end
            ktss_pkg::OP_ACCEPT: begin
                n_key    = i_key;
                n_status = 1'b0;
                n_found  = 1'b0;
                n_index  = '0;
            end
            ktss_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            ktss_pkg::OP_LOAD: begin
                if (r_count >= CW'(TABLE_DEPTH)) begin
                    n_status = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = r_count[AW-1:0];
                    wr_data = r_key;
                    n_count = r_count + CW'(1);
                end
            end
            ktss_pkg::OP_SRCH_INIT: begin
                n_lo  = '0;
                n_hix = r_count;
            end
            ktss_pkg::OP_SRCH_RD: begin
                rd_en   = 1'b1;
                rd_addr = mid;
            end
            ktss_pkg::OP_SRCH_CMP: begin
                if (r_rdata == r_key) begin
                    n_found = 1'b1;
                    n_index = ktss_pkg::t_index'(mid);
                end else if (r_key > r_rdata) begin
                    n_lo = mid_full + CW'(1);
                end else begin
                    n_hix = mid_full;
                end
            end
            ktss_pkg::OP_SORT_INIT: begin
                // push the whole table as the first range
                if (r_count >= CW'(2)) begin
                    stk_we = 1'b1;
                    stk_wa = '0;
                    stk_wd = {AW'(0), AW'(r_count - CW'(1))};
                    n_sp   = CW'(1);
                end
            end
            ktss_pkg::OP_POP: begin
                if (r_sp != '0) begin
                    stk_re = 1'b1;
                    n_sp   = r_sp - CW'(1);
                end
            end
            ktss_pkg::OP_POP_TAKE: begin
                n_slo   = r_sdata[2*AW-1:AW];
                n_shi   = r_sdata[AW-1:0];
                rd_en   = 1'b1;
                rd_addr = r_sdata[AW-1:0];
            end
            ktss_pkg::OP_PIVOT: begin
                n_pivot = r_rdata;
                n_ip    = r_slo;
                n_j     = r_slo;
            end
            ktss_pkg::OP_RDJ: begin
                rd_en   = 1'b1;
                rd_addr = (r_j == r_shi) ? r_ip : r_j;
            end
            ktss_pkg::OP_CMPJ: begin
                n_vj = r_rdata;
                if (r_rdata > r_pivot) begin
                    n_j = r_j + AW'(1);
                end else if (r_ip == r_j) begin
                    n_ip = r_ip + AW'(1);
                    n_j  = r_j + AW'(1);
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ip;
                end
            end
            ktss_pkg::OP_SWPA: begin
                n_vi    = r_rdata;
                wr_en   = 1'b1;
                wr_addr = r_ip;
                wr_data = r_vj;
            end
            ktss_pkg::OP_SWPB: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_vi;
                n_ip    = r_ip + AW'(1);
                n_j     = r_j + AW'(1);
            end
            ktss_pkg::OP_FIN_WA: begin
                n_vi    = r_rdata;
                wr_en   = 1'b1;
                wr_addr = r_ip;
                wr_data = r_pivot;
            end
            ktss_pkg::OP_FIN_WB: begin
                wr_en   = 1'b1;
                wr_addr = r_shi;
                wr_data = r_vi;
            end
            ktss_pkg::OP_PUSH_L: begin
                stk_wd = {r_slo, r_ip - AW'(1)};
                if (CW'(r_ip) > CW'(r_slo) + CW'(1) && r_sp < CW'(TABLE_DEPTH)) begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + CW'(1);
                end
            end
            ktss_pkg::OP_PUSH_R: begin
                stk_wd = {r_ip + AW'(1), r_shi};
                if (CW'(r_ip) + CW'(1) < CW'(r_shi) && r_sp < CW'(TABLE_DEPTH)) begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + CW'(1);
                end
            end
            ktss_pkg::OP_EMIT: begin
                n_ostatus = r_status;
                n_ofound  = r_found;
                n_oindex  = r_index;
            end
            default: begin
            end
        endcase
    end

    // Key table port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_key_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_key_mem[rd_addr];
        end
    end

    // Range stack port
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_sdata <= r_stk_mem[stk_ra];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sp    <= '0;
        end else begin
            r_count <= n_count;
            r_sp    <= n_sp;
        end
    end

    // Payload state
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_pivot   <= n_pivot;
        r_vj      <= n_vj;
        r_vi      <= n_vi;
        r_lo      <= n_lo;
        r_hix     <= n_hix;
        r_slo     <= n_slo;
        r_shi     <= n_shi;
        r_ip      <= n_ip;
        r_j       <= n_j;
        r_status  <= n_status;
        r_found   <= n_found;
        r_index   <= n_index;
        r_ostatus <= n_ostatus;
        r_ofound  <= n_ofound;
        r_oindex  <= n_oindex;
    end

endmodule

>>> src/ktss_ctrl.sv
module ktss_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ktss_pkg::CMD_W-1:0] i_cmd,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output ktss_pkg::t_dp_op           o_op,
    input  ktss_pkg::t_dp_stat         i_stat
);

    ktss_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ktss_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (ktss_pkg::t_cmd'(i_cmd))
                        ktss_pkg::CMD_CLEAR:  n_state = ktss_pkg::ST_CLEAR;
                        ktss_pkg::CMD_LOAD:   n_state = ktss_pkg::ST_LOAD;
                        ktss_pkg::CMD_SORT:   n_state = ktss_pkg::ST_SORT_INIT;
                        ktss_pkg::CMD_SEARCH: n_state = ktss_pkg::ST_SRCH_INIT;
                        default:              n_state = ktss_pkg::ST_IDLE;
                    endcase
                end
            end
            ktss_pkg::ST_CLEAR:     n_state = ktss_pkg::ST_EMIT;
            ktss_pkg::ST_LOAD:      n_state = ktss_pkg::ST_EMIT;
            ktss_pkg::ST_SRCH_INIT: n_state = ktss_pkg::ST_SRCH_RD;
            ktss_pkg::ST_SRCH_RD: begin
                n_state = i_stat.srch_open ? ktss_pkg::ST_SRCH_CMP : ktss_pkg::ST_EMIT;
            end
            ktss_pkg::ST_SRCH_CMP: begin
                n_state = i_stat.hit ? ktss_pkg::ST_EMIT : ktss_pkg::ST_SRCH_RD;
            end
            ktss_pkg::ST_SORT_INIT: begin
                n_state = i_stat.count_lt2 ? ktss_pkg::ST_EMIT : ktss_pkg::ST_POP;
            end
            ktss_pkg::ST_POP: begin
                n_state = i_stat.sp_zero ? ktss_pkg::ST_EMIT : ktss_pkg::ST_POP_TAKE;
            end
            ktss_pkg::ST_POP_TAKE:  n_state = ktss_pkg::ST_PIVOT;
            ktss_pkg::ST_PIVOT:     n_state = ktss_pkg::ST_RDJ;
            ktss_pkg::ST_RDJ: begin
                n_state = i_stat.j_at_hi ? ktss_pkg::ST_FIN_WA : ktss_pkg::ST_CMPJ;
            end
            ktss_pkg::ST_CMPJ: begin
                n_state = i_stat.swap_need ? ktss_pkg::ST_SWPA : ktss_pkg::ST_RDJ;
            end
            ktss_pkg::ST_SWPA:      n_state = ktss_pkg::ST_SWPB;
            ktss_pkg::ST_SWPB:      n_state = ktss_pkg::ST_RDJ;
            ktss_pkg::ST_FIN_WA:    n_state = ktss_pkg::ST_FIN_WB;
            ktss_pkg::ST_FIN_WB:    n_state = ktss_pkg::ST_PUSH_L;
            ktss_pkg::ST_PUSH_L:    n_state = ktss_pkg::ST_PUSH_R;
            ktss_pkg::ST_PUSH_R:    n_state = ktss_pkg::ST_POP;
            ktss_pkg::ST_EMIT: begin
                if (slot_free) begin
                    n_state = ktss_pkg::ST_IDLE;
                end
            end
            default:                n_state = ktss_pkg::ST_IDLE;
        endcase
    end

    // Outputs per state
    always_comb begin
        o_in_ready = 1'b0;
        o_op       = ktss_pkg::OP_NOP;
        unique case (r_state)
            ktss_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_op       = i_in_valid ? ktss_pkg::OP_ACCEPT : ktss_pkg::OP_NOP;
            end
            ktss_pkg::ST_CLEAR:     o_op = ktss_pkg::OP_CLEAR;
            ktss_pkg::ST_LOAD:      o_op = ktss_pkg::OP_LOAD;
            ktss_pkg::ST_SRCH_INIT: o_op = ktss_pkg::OP_SRCH_INIT;
            ktss_pkg::ST_SRCH_RD:   o_op = ktss_pkg::OP_SRCH_RD;
            ktss_pkg::ST_SRCH_CMP:  o_op = ktss_pkg::OP_SRCH_CMP;
            ktss_pkg::ST_SORT_INIT: o_op = ktss_pkg::OP_SORT_INIT;
            ktss_pkg::ST_POP:       o_op = ktss_pkg::OP_POP;
            ktss_pkg::ST_POP_TAKE:  o_op = ktss_pkg::OP_POP_TAKE;
            ktss_pkg::ST_PIVOT:     o_op = ktss_pkg::OP_PIVOT;
            ktss_pkg::ST_RDJ:       o_op = ktss_pkg::OP_RDJ;
            ktss_pkg::ST_CMPJ:      o_op = ktss_pkg::OP_CMPJ;
            ktss_pkg::ST_SWPA:      o_op = ktss_pkg::OP_SWPA;
            ktss_pkg::ST_SWPB:      o_op = ktss_pkg::OP_SWPB;
            ktss_pkg::ST_FIN_WA:    o_op = ktss_pkg::OP_FIN_WA;
            ktss_pkg::ST_FIN_WB:    o_op = ktss_pkg::OP_FIN_WB;
            ktss_pkg::ST_PUSH_L:    o_op = ktss_pkg::OP_PUSH_L;
            ktss_pkg::ST_PUSH_R:    o_op = ktss_pkg::OP_PUSH_R;
            ktss_pkg::ST_EMIT: begin
                o_op = slot_free ? ktss_pkg::OP_EMIT : ktss_pkg::OP_NOP;
            end
            default:                o_op = ktss_pkg::OP_NOP;
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == ktss_pkg::ST_EMIT && slot_free) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ktss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/key_table_sort_and_search.sv
// Channel   Dir  Payload                        Handshake
// i_in      in   cmd[1:0], key[63:0]            valid/ready
// o_out     out  status, found, index[9:0]      valid/ready
//
// One command word is taken at a time.
// A search sets up its range, then reads and compares one probe at a time,
// through the single registered read port of the key table.
// A sort partitions one range at a time, taken from the range stack; input stays
// stalled until it finishes. Reset needs no clearing pass.
// A finished result waits in the output register; while that is stalled, the next result waits in ST_EMIT.
module key_table_sort_and_search #(
    parameter int TABLE_DEPTH = ktss_pkg::TABLE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ktss_in_if.sink    i_in,
    ktss_out_if.source o_out
);

    ktss_pkg::t_dp_op   op;
    ktss_pkg::t_dp_stat stat;

    // Sequence the commands
    ktss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_cmd       (i_in.cmd),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_op        (op),
        .i_stat      (stat)
    );

    // Table, stack and result registers
    ktss_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (op),
        .i_key    (i_in.key),
        .o_stat   (stat),
        .o_status (o_out.status),
        .o_found  (o_out.found),
        .o_index  (o_out.index)
    );

endmodule

>>> src/ktss_checker.sv
`include "key_table_sort_and_search_defines.svh"

module ktss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_status,
    input logic                       i_found,
    input logic [ktss_pkg::IDX_W-1:0] i_index
);

    // Hold a stalled result word
    `KTSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable({i_status, i_found, i_index}))

    // Miss reports index zero
    `KTSS_ASSERT_SAME(a_miss_idx, i_clk, i_rst_n, i_out_valid && !i_found, i_index == '0)

    // Full and found never together
    `KTSS_ASSERT_SAME(a_excl, i_clk, i_rst_n, i_out_valid, !(i_status && i_found))

    // One command word at a time
    `KTSS_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind key_table_sort_and_search ktss_checker u_ktss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_found     (o_out.found),
    .i_index     (o_out.index)
);
